// ----- rtl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer package
// Shared types, register and mode codes, segment tables and the frame helper
// functions used by the composer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int SSC_CHANNELS   = 3;
  localparam int SSC_CFG_IDX_W  = 2;
  localparam int SSC_CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [SSC_CFG_IDX_W-1:0] CFG_TEST_MODE      = 2'd0;
  localparam logic [SSC_CFG_IDX_W-1:0] CFG_CUSTOM_ENABLE  = 2'd1;
  localparam logic [SSC_CFG_IDX_W-1:0] CFG_CUSTOM_PATTERN = 2'd2;
  localparam logic [SSC_CFG_IDX_W-1:0] CFG_BLINK_TICKS    = 2'd3;

  // Test mode codes.
  localparam logic [2:0] TM_NORMAL   = 3'd0;
  localparam logic [2:0] TM_ALL_LIT  = 3'd1;
  localparam logic [2:0] TM_DIGITS   = 3'd2;
  localparam logic [2:0] TM_ALL_HIGH = 3'd3;
  localparam logic [2:0] TM_ALL_LOW  = 3'd4;

  localparam logic [15:0] BLINK_TICKS_RST = 16'd400;

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] NINE_CHAR = 8'h39;
  localparam logic [7:0] BLANK_SEG = 8'hFF;

  // "12.34" with the first character in the low byte, and 0.45 in Q0.8.
  localparam logic [39:0] DEMO_TEXT = 40'h34332E3231;
  localparam logic [8:0]  DEMO_FRAC = 9'd115;

  typedef struct packed {
    logic [1:0]  channel;
    logic [39:0] text;
    logic [8:0]  speed_frac;
    logic [8:0]  load_frac;
    logic        missing;
    logic        edit_active;
    logic        overload;
    logic        paused;
    logic        running;
    logic [31:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0] channel_out;
    logic [7:0] digit0;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic [7:0] digit3;
    logic [7:0] led_byte0;
    logic [7:0] led_byte1;
  } out_item_t;

  typedef struct packed {
    logic [SSC_CFG_IDX_W-1:0]  index;
    logic [SSC_CFG_DATA_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic [2:0]  test_mode;
    logic        custom_enable;
    logic [7:0]  custom_pattern;
    logic [15:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic [31:0] toggle_time;
    logic [15:0] led_store;
  } chan_state_t;

  typedef struct packed {
    logic        en;
    logic        toggle_en;
    logic [1:0]  chan;
    logic [31:0] toggle_time;
    logic [15:0] led_store;
  } state_wr_t;

  // Segment wiring used at digit positions 0 and 2.
  function automatic logic [7:0] seg_even(input logic [3:0] v);
    case (v)
      4'd0: return 8'hDE;
      4'd1: return 8'h82;
      4'd2: return 8'hEC;
      4'd3: return 8'hE6;
      4'd4: return 8'hB2;
      4'd5: return 8'h76;
      4'd6: return 8'h7E;
      4'd7: return 8'hC2;
      4'd8: return 8'hFE;
      4'd9: return 8'hF6;
      default: return 8'h00;
    endcase
  endfunction

  // Segment wiring used at digit positions 1 and 3.
  function automatic logic [7:0] seg_odd(input logic [3:0] v);
    case (v)
      4'd0: return 8'hFA;
      4'd1: return 8'h82;
      4'd2: return 8'hDC;
      4'd3: return 8'hCE;
      4'd4: return 8'hA6;
      4'd5: return 8'h6E;
      4'd6: return 8'h7E;
      4'd7: return 8'hC2;
      4'd8: return 8'hFE;
      4'd9: return 8'hEE;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] text_char(input logic [39:0] text, input logic [2:0] pos);
    case (pos)
      3'd0: return text[7:0];
      3'd1: return text[15:8];
      3'd2: return text[23:16];
      3'd3: return text[31:24];
      3'd4: return text[39:32];
      default: return 8'h00;
    endcase
  endfunction

  // Four active-low digit bytes, digit0 in the low byte. A dot clears the
  // decimal point of the digit before it and is skipped.
  function automatic logic [31:0] make_digits(input logic [39:0] text);
    logic [3:0][7:0] d;
    logic [2:0]      shift;
    logic [7:0]      c;
    logic [3:0]      v;
    d     = '1;
    shift = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (text_char(text, 3'(i) + shift) == DOT_CHAR) begin
        shift = shift + 3'd1;
        if (i > 0) begin
          d[i-1] = d[i-1] & 8'hFE;
        end
      end
      c = text_char(text, 3'(i) + shift);
      v = c[3:0];
      if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
        d[i] = (i % 2 == 0) ? ~seg_even(v) : ~seg_odd(v);
      end else begin
        d[i] = BLANK_SEG;
      end
    end
    return d;
  endfunction

  // Eight-step bar: n = min(8, (frac*8 + 128) >> 8), bit 0 on unless frac is zero.
  function automatic logic [7:0] bar8(input logic [8:0] frac);
    logic [9:0] n;
    logic [8:0] ones;
    n = (10'(frac) + 10'd16) >> 5;
    if (n > 10'd8) n = 10'd8;
    ones = (9'd1 << n[3:0]) - 9'd1;
    return (frac == 9'd0) ? 8'h00 : (ones[7:0] | 8'h01);
  endfunction

  // Four-step bar: n = min(4, (frac*4 + 128) >> 8), bit 0 on unless frac is zero.
  function automatic logic [3:0] bar4(input logic [8:0] frac);
    logic [9:0] n;
    logic [4:0] ones;
    n = (10'(frac) + 10'd32) >> 6;
    if (n > 10'd4) n = 10'd4;
    ones = (5'd1 << n[2:0]) - 5'd1;
    return (frac == 9'd0) ? 4'h0 : (ones[3:0] | 4'h1);
  endfunction

  function automatic logic [15:0] led_word(input logic [8:0] speed, input logic [8:0] load);
    return {bar4(load), bar8(speed), 4'h0};
  endfunction

  localparam logic [31:0] DEMO_DIGITS = make_digits(DEMO_TEXT);
  localparam logic [15:0] DEMO_WORD   = led_word(DEMO_FRAC, DEMO_FRAC) | 16'h0003;
  // The demo pattern shows its LED bytes swapped.
  localparam logic [15:0] DEMO_LEDS   = {DEMO_WORD[7:0], DEMO_WORD[15:8]};

endpackage

`default_nettype wire

// ----- rtl/ssc_if.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer channel interfaces
// Valid/ready channels for input items, result frames and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_in_if;
  logic               valid;
  logic               ready;
  ssc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssc_out_if;
  logic               valid;
  logic               ready;
  ssc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssc_cfg_if;
  logic               valid;
  logic               ready;
  ssc_pkg::cfg_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ssc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer configuration registers
// Accepts register write requests and holds test, lamp and blink settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_cfg_regs (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ssc_cfg_if.sink    cfg_chan,
  output ssc_pkg::cfg_t cfg
);
  import ssc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_chan.ready = 1'b1;
  assign wr = cfg_chan.valid && cfg_chan.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_chan.data.index)
        CFG_TEST_MODE:      cfg_nxt.test_mode      = cfg_chan.data.data[2:0];
        CFG_CUSTOM_ENABLE:  cfg_nxt.custom_enable  = cfg_chan.data.data[0];
        CFG_CUSTOM_PATTERN: cfg_nxt.custom_pattern = cfg_chan.data.data[7:0];
        CFG_BLINK_TICKS:    cfg_nxt.blink_ticks    = cfg_chan.data.data[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.test_mode      <= TM_NORMAL;
      cfg_r.custom_enable  <= 1'b0;
      cfg_r.custom_pattern <= 8'h00;
      cfg_r.blink_ticks    <= BLINK_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/ssc_state.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer per-channel state
// Blink toggle time and last LED bytes of every channel, one read and one
// write port selected by channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_state #(
  parameter int CHANNELS = ssc_pkg::SSC_CHANNELS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     rd_chan,
  output ssc_pkg::chan_state_t rd,
  input  ssc_pkg::state_wr_t  wr
);
  import ssc_pkg::*;

  logic [31:0] toggle_r [CHANNELS];
  logic [15:0] store_r  [CHANNELS];

  // Channels past the array read as zero; the composer blanks them anyway.
  always_comb begin
    rd = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (5'(rd_chan) == 5'(i)) begin
        rd.toggle_time = toggle_r[i];
        rd.led_store   = store_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        toggle_r[i] <= 32'd0;
        store_r[i]  <= 16'd0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (wr.en && 5'(wr.chan) == 5'(i)) begin
          store_r[i] <= wr.led_store;
          if (wr.toggle_en) begin
            toggle_r[i] <= wr.toggle_time;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssc_compose.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer frame logic
// Builds one channel frame from an input item, the settings and the channel's
// stored state, and the state update that goes with it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_compose #(
  parameter int CHANNELS = ssc_pkg::SSC_CHANNELS
) (
  input  ssc_pkg::in_item_t    item,
  input  ssc_pkg::cfg_t        cfg,
  input  ssc_pkg::chan_state_t st,
  output ssc_pkg::out_item_t   frame,
  output ssc_pkg::state_wr_t   upd
);
  import ssc_pkg::*;

  logic        in_range;
  logic [31:0] elapsed;
  logic        window;
  logic        expire;
  logic [15:0] run_word;
  logic [31:0] digits;
  logic [15:0] leds;
  logic        toggle_en;

  assign in_range = 5'(item.channel) < 5'(CHANNELS);
  assign elapsed  = item.now_tick - st.toggle_time;
  assign window   = item.edit_active && (elapsed < 32'(cfg.blink_ticks));
  assign expire   = item.edit_active && (elapsed > 32'({cfg.blink_ticks, 1'b0}));
  assign run_word = led_word(item.speed_frac, item.running ? item.load_frac : 9'd0)
                  | {13'd0, item.running, item.paused, item.overload};

  always_comb begin
    digits    = '1;
    leds      = 16'h0000;
    toggle_en = 1'b0;
    if (in_range) begin
      if (cfg.test_mode == TM_NORMAL && cfg.custom_enable) begin
        digits = {4{cfg.custom_pattern}};
        leds   = {2{cfg.custom_pattern}};
      end else begin
        case (cfg.test_mode)
          TM_ALL_LIT: begin
            digits = 32'h0;
            leds   = 16'hFFFF;
          end
          TM_DIGITS: begin
            digits = DEMO_DIGITS;
            leds   = DEMO_LEDS;
          end
          TM_ALL_HIGH: begin
            leds = 16'hFFFF;
          end
          TM_ALL_LOW: begin
            digits = 32'h0;
          end
          default: begin
            // Normal mode, and the undefined modes behave the same way.
            if (item.missing && !item.edit_active) begin
              digits = '1;
            end else if (window) begin
              leds = st.led_store;
            end else begin
              toggle_en = expire;
              digits    = make_digits(item.text);
              leds      = run_word;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    frame.channel_out = item.channel;
    frame.digit0      = digits[7:0];
    frame.digit1      = digits[15:8];
    frame.digit2      = digits[23:16];
    frame.digit3      = digits[31:24];
    frame.led_byte0   = leds[7:0];
    frame.led_byte1   = leds[15:8];
  end

  always_comb begin
    upd.en          = in_range;
    upd.toggle_en   = toggle_en;
    upd.chan        = item.channel;
    upd.toggle_time = item.now_tick;
    upd.led_store   = leds;
  end

endmodule

`default_nettype wire

// ----- rtl/seven_segment_channel_composer.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer
// Composes one display frame (four segment bytes, two LED bytes) per request.
//
//   Channel    Dir  Payload                              Accepted when
//   cfg_chan   in   register index, write data           valid & ready (ready=1)
//   in_chan    in   channel, text, fractions, flags, tick valid & ready
//   out_chan   out  channel_out, digit0..3, led_byte0..1 valid & ready
//
// A request waits in the input register and is composed on its way into the
// output register, from which out_chan presents its frame. One request is taken
// per cycle while out_chan accepts frames; per-channel state is written as
// each frame is registered, so the next request of the same channel already
// sees it. A stalled output holds both registers and drops in_chan.ready only
// when both are full. Reset restores the default settings and clears all
// per-channel state.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_channel_composer #(
  parameter int CHANNELS = ssc_pkg::SSC_CHANNELS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ssc_cfg_if.sink   cfg_chan,
  ssc_in_if.sink    in_chan,
  ssc_out_if.source out_chan
);
  import ssc_pkg::*;

  cfg_t        cfg;
  chan_state_t st_rd;
  state_wr_t   st_upd;
  state_wr_t   st_wr;
  out_item_t   frame;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  logic      advance;
  logic      in_acc;

  ssc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  ssc_state #(.CHANNELS(CHANNELS)) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_chan (s1_item_r.channel),
    .rd      (st_rd),
    .wr      (st_wr)
  );

  ssc_compose #(.CHANNELS(CHANNELS)) u_compose (
    .item  (s1_item_r),
    .cfg   (cfg),
    .st    (st_rd),
    .frame (frame),
    .upd   (st_upd)
  );

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    st_wr    = st_upd;
    st_wr.en = st_upd.en && advance;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_chan.data;
    end
    if (advance) begin
      out_item_r <= frame;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

`ifndef SYNTH
  // A request that leaves the input register always shows up as a frame.
  a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("composed frame did not reach the output register");

  // The input register never drops a request while the output is stalled.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |=> (s1_valid_r && out_valid_r))
    else $error("pending request lost during output stall");

  // Channels beyond the configured count always come out blank.
  a_blank_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (5'(out_item_r.channel_out) >= 5'(CHANNELS))) |->
      (out_item_r.digit0 == BLANK_SEG && out_item_r.digit1 == BLANK_SEG &&
       out_item_r.digit2 == BLANK_SEG && out_item_r.digit3 == BLANK_SEG &&
       out_item_r.led_byte0 == 8'h00 && out_item_r.led_byte1 == 8'h00))
    else $error("out-of-range channel produced a lit frame");

  // State is only written when a frame moves into the output register.
  a_state_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |-> (s1_valid_r && advance))
    else $error("channel state written without a composed frame");
`endif

endmodule

`default_nettype wire

// ----- tb/ssc_frame_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer frame scoreboard
// Predicts the display frame of every accepted request from its own copy of
// the settings and the per-channel blink and LED state, and checks the frames
// that the composer delivers against those predictions in order.
// ----------------------------------------------------------------------------
package ssc_frame_sb_pkg;

  import ssc_pkg::*;

  // Segment wirings, digit value 0 in the low byte.
  localparam logic [9:0][7:0] EVEN_WIRING = {8'hF6, 8'hFE, 8'hC2, 8'h7E, 8'h76,
                                             8'hB2, 8'hE6, 8'hEC, 8'h82, 8'hDE};
  localparam logic [9:0][7:0] ODD_WIRING  = {8'hEE, 8'hFE, 8'hC2, 8'h7E, 8'h6E,
                                             8'hA6, 8'hCE, 8'hDC, 8'h82, 8'hFA};

  class frame_scoreboard;
    logic [2:0]  test_mode;
    logic        custom_enable;
    logic [7:0]  custom_pattern;
    logic [15:0] blink_ticks;
    logic [31:0] toggle_time [SSC_CHANNELS];
    logic [15:0] led_store [SSC_CHANNELS];
    out_item_t   frames_due [$];
    int unsigned errors;
    int unsigned frames_seen;
    int unsigned requests_seen;

    function new();
      test_mode      = TM_NORMAL;
      custom_enable  = 1'b0;
      custom_pattern = 8'h00;
      blink_ticks    = BLINK_TICKS_RST;
      foreach (toggle_time[i]) toggle_time[i] = '0;
      foreach (led_store[i]) led_store[i] = '0;
      errors        = 0;
      frames_seen   = 0;
      requests_seen = 0;
    endfunction

    function void write_reg(logic [SSC_CFG_IDX_W-1:0] idx, logic [SSC_CFG_DATA_W-1:0] value);
      case (idx)
        CFG_TEST_MODE:      test_mode = value[2:0];
        CFG_CUSTOM_ENABLE:  custom_enable = value[0];
        CFG_CUSTOM_PATTERN: custom_pattern = value[7:0];
        CFG_BLINK_TICKS:    blink_ticks = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] char_at(logic [39:0] text, int pos);
      if (pos >= 5) return 8'h00;
      return text[8*pos +: 8];
    endfunction

    // Digit bytes with digit0 in the low byte.
    function logic [31:0] digits_of(logic [39:0] text);
      logic [7:0] d [4];
      logic [7:0] c;
      int         skip;
      int         v;
      skip = 0;
      for (int i = 0; i < 4; i++) begin
        d[i] = BLANK_SEG;
        if (char_at(text, i + skip) == DOT_CHAR) begin
          skip++;
          if (i > 0) d[i-1][0] = 1'b0;
        end
        c = char_at(text, i + skip);
        if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
          v = c - ZERO_CHAR;
          d[i] = (i % 2 == 0) ? ~EVEN_WIRING[v] : ~ODD_WIRING[v];
        end
      end
      return {d[3], d[2], d[1], d[0]};
    endfunction

    function logic [7:0] bar_steps(logic [8:0] frac, int unsigned steps);
      int unsigned n;
      if (frac == 9'd0) return 8'h00;
      n = (frac * steps + 128) >> 8;
      if (n > steps) n = steps;
      return 8'(((1 << n) - 1) | 1);
    endfunction

    function logic [15:0] bar_word(logic [8:0] speed, logic [8:0] load);
      logic [7:0] s;
      logic [7:0] l;
      s = bar_steps(speed, 8);
      l = bar_steps(load, 4);
      return {l[3:0], s, 4'h0};
    endfunction

    function string frame_text(out_item_t f);
      return $sformatf("ch %0d digits %h %h %h %h leds %h %h", f.channel_out,
                       f.digit0, f.digit1, f.digit2, f.digit3, f.led_byte0, f.led_byte1);
    endfunction

    function void predict_frame(in_item_t req);
      out_item_t   f;
      logic [31:0] digs;
      logic [15:0] w;
      logic [31:0] elapsed;
      int          ch;
      ch    = req.channel;
      digs  = '1;
      w     = '0;
      requests_seen++;
      if (ch < SSC_CHANNELS) begin
        if (test_mode == TM_NORMAL && custom_enable) begin
          digs = {4{custom_pattern}};
          w    = {2{custom_pattern}};
        end else if (test_mode == TM_ALL_LIT) begin
          digs = '0;
          w    = '1;
        end else if (test_mode == TM_DIGITS) begin
          digs = digits_of(DEMO_TEXT);
          w    = bar_word(DEMO_FRAC, DEMO_FRAC) | 16'h0003;
          w    = {w[7:0], w[15:8]};
        end else if (test_mode == TM_ALL_HIGH) begin
          w = '1;
        end else if (test_mode == TM_ALL_LOW) begin
          digs = '0;
        end else if (req.missing && !req.edit_active) begin
          // An absent pump shows a dark frame.
        end else begin
          elapsed = req.now_tick - toggle_time[ch];
          if (req.edit_active && elapsed < {16'h0, blink_ticks}) begin
            w = led_store[ch];
          end else begin
            if (req.edit_active && elapsed > {15'h0, blink_ticks, 1'b0})
              toggle_time[ch] = req.now_tick;
            digs = digits_of(req.text);
            w    = bar_word(req.speed_frac, req.running ? req.load_frac : 9'd0);
            w[0] = w[0] | req.overload;
            w[1] = w[1] | req.paused;
            w[2] = w[2] | req.running;
          end
        end
        led_store[ch] = w;
      end
      f.channel_out = req.channel;
      {f.digit3, f.digit2, f.digit1, f.digit0} = digs;
      f.led_byte0 = w[7:0];
      f.led_byte1 = w[15:8];
      frames_due.push_back(f);
    endfunction

    function void check_frame(out_item_t got);
      out_item_t want;
      frames_seen++;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Frame with no request pending: %s", frame_text(got));
        return;
      end
      want = frames_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("Frame mismatch #%0d", errors);
          $display("  expected %s", frame_text(want));
          $display("  actual   %s", frame_text(got));
        end
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Seven-segment channel composer testbench
// Drives directed frames covering dot handling, bars, test modes, blanking
// and edit blinking, then random requests under several register settings,
// with random gaps on the request side and random stalls on the frame side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;
  import ssc_frame_sb_pkg::*;

  localparam int         IDLE_LIMIT     = 2000;
  localparam logic [2:0] TM_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] TM_UNDEF_LAST  = 3'd7;
  localparam logic [1:0] BAD_CHANNEL    = 2'(SSC_CHANNELS);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssc_in_if  in_bus ();
  ssc_out_if out_bus ();
  ssc_cfg_if cfg_bus ();

  seven_segment_channel_composer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  frame_scoreboard sb;
  logic [31:0]     sim_tick = '0;
  logic [15:0]     cur_blink = BLINK_TICKS_RST;
  int              settings_applied = 0;
  int              idle_cycles = 0;

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk_request(input logic [1:0] ch, input logic [39:0] text,
                                          input logic [8:0] speed, input logic [8:0] load,
                                          input logic [4:0] flags, input logic [31:0] now);
    in_item_t r;
    r.channel    = ch;
    r.text       = text;
    r.speed_frac = speed;
    r.load_frac  = load;
    {r.missing, r.edit_active, r.overload, r.paused, r.running} = flags;
    r.now_tick   = now;
    return r;
  endfunction

  function automatic logic [7:0] speed_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'(ZERO_CHAR + $urandom_range(0, 9));
    if (r < 85) return DOT_CHAR;
    return 8'($urandom);
  endfunction

  function automatic logic [8:0] pick_frac();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 9'd0;
    if (r == 1) return 9'd256;
    return 9'($urandom_range(1, 255));
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    int       span;
    r.channel = ($urandom_range(0, 19) == 0) ? BAD_CHANNEL
                                             : 2'($urandom_range(0, SSC_CHANNELS - 1));
    if ($urandom_range(0, 9) == 0) begin
      r.text = {8'($urandom), $urandom};
    end else begin
      for (int k = 0; k < 5; k++) r.text[8*k +: 8] = speed_char();
    end
    r.speed_frac  = pick_frac();
    r.load_frac   = pick_frac();
    r.missing     = ($urandom_range(0, 4) == 0);
    r.edit_active = 1'($urandom_range(0, 1));
    r.overload    = 1'($urandom_range(0, 1));
    r.paused      = 1'($urandom_range(0, 1));
    r.running     = 1'($urandom_range(0, 1));
    // Small tick steps keep the blink windows opening and closing.
    span = (cur_blink == 16'd0) ? 64 : int'(cur_blink);
    if ($urandom_range(0, 29) == 0) sim_tick = $urandom;
    else sim_tick = sim_tick + $urandom_range(0, span / 3 + 2);
    r.now_tick = sim_tick;
    return r;
  endfunction

  task automatic send_request(input in_item_t req, input bit allow_gaps);
    int gap;
    gap = allow_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= req;
    do @(posedge clk); while (!in_bus.ready);
    sb.predict_frame(req);
  endtask

  task automatic write_reg(input logic [SSC_CFG_IDX_W-1:0] idx,
                           input logic [SSC_CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= cfg_req_t'{idx, value};
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, value);
  endtask

  // Settings change only once every frame already requested has come out.
  task automatic apply_settings(input logic [2:0] mode, input logic ce,
                                input logic [7:0] pattern, input logic [15:0] blink);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    write_reg(CFG_TEST_MODE, {13'($urandom), mode});
    write_reg(CFG_CUSTOM_ENABLE, {15'($urandom), ce});
    write_reg(CFG_CUSTOM_PATTERN, {8'($urandom), pattern});
    write_reg(CFG_BLINK_TICKS, blink);
    cfg_bus.valid <= 1'b0;
    cur_blink = blink;
    settings_applied++;
  endtask

  // Frame side back-pressure.
  initial begin
    int run_len;
    int hold;
    out_bus.ready = 1'b0;
    wait (rst_n);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      out_bus.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_frame(out_bus.data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request or frame moved for %0d cycles", IDLE_LIMIT);
      $display("[seven_segment_channel_composer] ERROR");
      $finish;
    end
  end

  initial begin
    logic [2:0]  mode_sel;
    logic        ce_sel;
    logic [15:0] blink_sel;
    int          directed_count;
    int          r;
    sb = new();
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Text handling and bars under the reset settings.
    send_request(mk_request(2'd0, 40'h34332E3231, 9'd0, 9'd0, 5'b00000, 32'd0), 1);
    send_request(mk_request(2'd1, 40'h343332312E, 9'd256, 9'd256, 5'b00111, 32'd16), 1);
    send_request(mk_request(2'd2, 40'h33322E2E31, 9'd1, 9'd1, 5'b00101, 32'd20), 1);
    send_request(mk_request(2'd0, 40'h7A39204241, 9'd128, 9'd127, 5'b00010, 32'd30), 1);
    send_request(mk_request(2'd1, 40'h332E322E31, 9'd255, 9'd200, 5'b00001, 32'd40), 1);
    send_request(mk_request(BAD_CHANNEL, 40'h3938373635, 9'd100, 9'd100, 5'b00111, 32'd50), 1);
    send_request(mk_request(2'd1, 40'h3130393837, 9'd60, 9'd60, 5'b10111, 32'd60), 1);
    // Edit blinking on channel 2: window, plain frame, re-arm, window, wrap.
    send_request(mk_request(2'd2, 40'h3938373635, 9'd33, 9'd90, 5'b00111, 32'd70), 1);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd16, 9'd48, 5'b11111, 32'd100), 1);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd16, 9'd48, 5'b01001, 32'd500), 1);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd16, 9'd48, 5'b01000, 32'd900), 1);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd16, 9'd48, 5'b01000, 32'd1000), 1);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd77, 9'd48, 5'b01110, 32'hFFFF_FF00), 1);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd77, 9'd48, 5'b01000, 32'h0000_0010), 1);
    send_request(mk_request(2'd0, 40'hFF_FFFF_FFFF, 9'd256, 9'd256, 5'b11111, 32'hFFFF_FFFF), 1);

    // Test patterns, including the undefined modes that act as normal.
    apply_settings(TM_ALL_LIT, 1'b0, 8'h00, BLINK_TICKS_RST);
    send_request(mk_request(2'd0, 40'h3534333231, 9'd50, 9'd50, 5'b00111, 32'd10), 1);
    apply_settings(TM_DIGITS, 1'b0, 8'h00, BLINK_TICKS_RST);
    send_request(mk_request(2'd1, 40'h3534333231, 9'd50, 9'd50, 5'b11000, 32'd10), 1);
    apply_settings(TM_ALL_HIGH, 1'b0, 8'h00, BLINK_TICKS_RST);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd50, 9'd50, 5'b00000, 32'd10), 1);
    apply_settings(TM_ALL_LOW, 1'b1, 8'hFF, BLINK_TICKS_RST);
    send_request(mk_request(2'd0, 40'h3534333231, 9'd50, 9'd50, 5'b10000, 32'd10), 1);
    send_request(mk_request(BAD_CHANNEL, 40'h3534333231, 9'd50, 9'd50, 5'b00000, 32'd10), 1);
    apply_settings(TM_UNDEF_FIRST, 1'b1, 8'hA5, BLINK_TICKS_RST);
    send_request(mk_request(2'd1, 40'h3938373635, 9'd200, 9'd20, 5'b00111, 32'd20), 1);
    apply_settings(TM_UNDEF_LAST, 1'b0, 8'h5A, BLINK_TICKS_RST);
    send_request(mk_request(2'd0, 40'h302E2E3936, 9'd20, 9'd200, 5'b00101, 32'd30), 1);
    apply_settings(TM_NORMAL, 1'b1, 8'h00, BLINK_TICKS_RST);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd50, 9'd50, 5'b00111, 32'd40), 1);
    // A zero blink period never opens the window.
    apply_settings(TM_NORMAL, 1'b0, 8'h00, 16'd0);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd90, 9'd90, 5'b01111, 32'h20), 1);
    send_request(mk_request(2'd2, 40'h3534333231, 9'd90, 9'd90, 5'b11001, 32'h20), 1);
    directed_count = sb.requests_seen;

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: apply_settings(TM_NORMAL, 1'b0, 8'h00, 16'd1);
        1: apply_settings(TM_NORMAL, 1'b0, 8'hFF, 16'hFFFF);
        2: begin
          apply_settings(TM_NORMAL, 1'b0, 8'h00, 16'd3);
          sim_tick = 32'hFFFF_FF80;
        end
        3: apply_settings(TM_NORMAL, 1'b1, 8'hFF, BLINK_TICKS_RST);
        default: begin
          mode_sel = ($urandom_range(0, 99) < 65) ? TM_NORMAL
                                                   : 3'($urandom_range(TM_ALL_LIT, TM_UNDEF_LAST));
          ce_sel   = ($urandom_range(0, 99) < 15);
          r        = $urandom_range(0, 9);
          if (r < 4) blink_sel = 16'($urandom_range(1, 16));
          else if (r < 9) blink_sel = 16'($urandom_range(17, 2000));
          else blink_sel = 16'hFFFF;
          apply_settings(mode_sel, ce_sel, 8'($urandom), blink_sel);
        end
      endcase
      for (int k = 0; k < 115; k++) send_request(random_request(), (p % 4) != 3);
    end

    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d frames from %0d requests (%0d directed) across %0d register settings.",
             sb.frames_seen, sb.requests_seen, directed_count, settings_applied);
    $display("Mismatches or unexpected frames: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("[seven_segment_channel_composer] OK");
    end else begin
      $display("[seven_segment_channel_composer] ERROR");
    end
    $finish;
  end

endmodule
